>>> rtl/amo128_pkg.sv
// Package for the 128-bit atomic memory operation unit.
// Holds the sizes, operation codes, transfer payload types and the control/status structs.
// Depends on nothing.
package amo128_pkg;

    // Number of 128-bit words held. It must be a power of two, no larger than 1024.
    localparam int NUM_WORDS = 1024;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int TYPE_W    = 4;
    localparam int IDX_W     = 10;
    localparam int HALF_W    = 64;

    typedef enum logic [TYPE_W-1:0] {
        OP_LOAD     = 4'd0,
        OP_STORE    = 4'd1,
        OP_EXCHANGE = 4'd2,
        OP_CMPXCHG  = 4'd3,
        OP_ADD      = 4'd4,
        OP_SUB      = 4'd5,
        OP_AND      = 4'd6,
        OP_OR       = 4'd7,
        OP_XOR      = 4'd8
    } op_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [IDX_W-1:0]  word_index;
        logic [HALF_W-1:0] operand_low;
        logic [HALF_W-1:0] operand_high;
        logic [HALF_W-1:0] expected_low;
        logic [HALF_W-1:0] expected_high;
    } req_t;

    typedef struct packed {
        logic [HALF_W-1:0] prior_low;
        logic [HALF_W-1:0] prior_high;
        logic              swapped;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clear_wr;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic has_result;
        logic out_free;
    } status_t;

endpackage

>>> rtl/atomic_memory_op_128.sv
// A 128-bit atomic memory operation unit over 1024 words: load, store, exchange,
// compare-exchange, add, sub, and, or and xor, each as one indivisible read-modify-write.
// After reset the store is zeroed by a clearing pass over every word, during which no
// transfer is accepted on the request channel. Thereafter the word of each request is read
// from the single-ported store in the cycle of acceptance, and in the execution state the new
// value is written and the prior value placed in the result register. A request is accepted
// only while the unit is idle, so no new request is taken before the last one is executed;
// the result register holds one finished transfer, and an operation that returns a result
// waits in execution while that register is still occupied and not being taken. Stores and unused
// request codes give no result; unused codes leave the store unchanged. Uses amo128_pkg,
// amo128_ctrl and amo128_dp.
module atomic_memory_op_128 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  amo128_pkg::req_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output amo128_pkg::result_t m_data
);
    import amo128_pkg::*;

    cmd_t    cmd;
    status_t sts;

    amo128_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    amo128_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s_ready)
        else $error("Request accepted during the clearing pass.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Second request accepted while one is in execution.");

    a_exec_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && sts.has_result) |-> (!m_valid || m_ready))
        else $error("Result written over a transfer not yet taken.");

    a_exec_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !cmd.load_req && !cmd.clear_wr)
        else $error("Execution overlaps capture or clearing.");

endmodule

>>> rtl/amo128_ctrl.sv
// Controller state machine of the 128-bit atomic memory operation unit.
// Sequences the clearing pass, request capture and execution; uses amo128_pkg.
module amo128_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  amo128_pkg::status_t sts,
    output amo128_pkg::cmd_t    cmd
);
    import amo128_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!sts.has_result || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load_req = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = !sts.has_result || sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/amo128_dp.sv
// Datapath of the 128-bit atomic memory operation unit.
// Holds the word store, request register, operation logic and result register; uses amo128_pkg.
module amo128_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  amo128_pkg::req_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output amo128_pkg::result_t m_data,
    input  amo128_pkg::cmd_t    cmd,
    output amo128_pkg::status_t sts
);
    import amo128_pkg::*;

    logic [HALF_W-1:0] low_mem  [NUM_WORDS];
    logic [HALF_W-1:0] high_mem [NUM_WORDS];

    req_t              req_reg;
    logic [HALF_W-1:0] rd_low_reg;
    logic [HALF_W-1:0] rd_high_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic [2*HALF_W-1:0] prior_word;
    logic [2*HALF_W-1:0] operand_word;
    logic [2*HALF_W-1:0] expected_word;
    logic [2*HALF_W-1:0] new_word;
    logic                op_valid;
    logic                op_result;
    logic                swapped;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [2*HALF_W-1:0] wr_word;

    assign prior_word    = {rd_high_reg, rd_low_reg};
    assign operand_word  = {req_reg.operand_high, req_reg.operand_low};
    assign expected_word = {req_reg.expected_high, req_reg.expected_low};

    always_comb begin
        new_word  = prior_word;
        op_valid  = 1'b1;
        op_result = 1'b1;
        swapped   = 1'b0;
        case (op_t'(req_reg.req_type))
            OP_LOAD: begin
                new_word = prior_word;
            end
            OP_STORE: begin
                new_word  = operand_word;
                op_result = 1'b0;
            end
            OP_EXCHANGE: begin
                new_word = operand_word;
            end
            OP_CMPXCHG: begin
                if (prior_word == expected_word) begin
                    new_word = operand_word;
                    swapped  = 1'b1;
                end
            end
            OP_ADD: begin
                new_word = prior_word + operand_word;
            end
            OP_SUB: begin
                new_word = prior_word - operand_word;
            end
            OP_AND: begin
                new_word = prior_word & operand_word;
            end
            OP_OR: begin
                new_word = prior_word | operand_word;
            end
            OP_XOR: begin
                new_word = prior_word ^ operand_word;
            end
            default: begin
                op_valid  = 1'b0;
                op_result = 1'b0;
            end
        endcase
    end

    assign sts.has_result = op_result;
    assign sts.out_free   = !out_valid_reg || m_ready;
    assign sts.clear_last = (clr_addr_reg == ADDR_W'(NUM_WORDS - 1));

    always_comb begin
        if (cmd.clear_wr) begin
            mem_we  = 1'b1;
            wr_addr = clr_addr_reg;
            wr_word = '0;
        end else begin
            mem_we  = cmd.exec && op_valid;
            wr_addr = req_reg.word_index[ADDR_W-1:0];
            wr_word = new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            low_mem[wr_addr]  <= wr_word[HALF_W-1:0];
            high_mem[wr_addr] <= wr_word[2*HALF_W-1:HALF_W];
        end
        if (cmd.load_req) begin
            rd_low_reg  <= low_mem[s_data.word_index[ADDR_W-1:0]];
            rd_high_reg <= high_mem[s_data.word_index[ADDR_W-1:0]];
            req_reg     <= s_data;
        end
        if (cmd.exec && op_result) begin
            out_data_reg.prior_low  <= rd_low_reg;
            out_data_reg.prior_high <= rd_high_reg;
            out_data_reg.swapped    <= swapped;
        end
    end

    always_comb begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clear_wr) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec && op_result) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
